// ----- rtl/hex_xor_tea_block_decrypter_macros.svh -----
// assertion macros for the hex xor tea block decrypter
`ifndef HEX_XOR_TEA_BLOCK_DECRYPTER_MACROS_SVH
`define HEX_XOR_TEA_BLOCK_DECRYPTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define HXTD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("hxtd assertion failed");
`define HXTD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("hxtd forbidden condition seen");
`else
`define HXTD_ASSERT(lbl, clk, rst_n, prop)
`define HXTD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- rtl/hxtd_pkg.sv -----
`default_nettype none
package hxtd_pkg;

	localparam int TEA_ROUNDS = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] TEA_DELTA = 32'h9e3779b9;
	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam logic [7:0] ALPHA_ADJ = 8'd39;
	localparam logic [7:0] LOWER_LIM = 8'h60;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY0 = 3'd0,
		REG_KEY1 = 3'd1,
		REG_KEY2 = 3'd2,
		REG_KEY3 = 3'd3,
		REG_XOR  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} key_t;

	// one block request between front and back
	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        full;
		logic        eom;
	} blk_req_t;

	function automatic logic [7:0] hex_pair_byte(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] t;
		t = hi;
		if (hi > LOWER_LIM) t = t - ALPHA_ADJ;
		t = t - ASCII_ZERO;
		t = {t[3:0], 4'b0000};
		t = t + lo;
		if (lo > LOWER_LIM) t = t - ALPHA_ADJ;
		t = t - ASCII_ZERO;
		return t;
	endfunction

	function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] ka,
			input logic [31:0] kb, input logic [31:0] sum);
		return ({v[27:0], 4'b0000} + ka) ^ (v + sum) ^ ({5'b00000, v[31:5]} + kb);
	endfunction

	// one half round; partial blocks pass untouched
	function automatic blk_req_t tea_half(input blk_req_t r, input logic odd, input key_t key,
			input logic [31:0] sum);
		blk_req_t o;
		o = r;
		if (r.full) begin
			if (!odd) begin
				o.data[63:32] = r.data[63:32] - tea_mix(r.data[31:0], key.k2, key.k3, sum);
			end else begin
				o.data[31:0] = r.data[31:0] - tea_mix(r.data[63:32], key.k0, key.k1, sum);
			end
		end
		return o;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/hxtd_ifs.sv -----
`default_nettype none
interface hxtd_pair_if;
	logic       valid;
	logic       ready;
	logic [7:0] high_char;
	logic [7:0] low_char;
	logic       last_pair;

	modport source (output valid, output high_char, output low_char, output last_pair,
		input ready);
	modport sink (input valid, input high_char, input low_char, input last_pair,
		output ready);
endinterface

interface hxtd_block_if;
	logic        valid;
	logic        ready;
	logic [63:0] plain_block;
	logic [3:0]  byte_count;
	logic        was_decrypted;
	logic        end_of_message;

	modport source (output valid, output plain_block, output byte_count,
		output was_decrypted, output end_of_message, input ready);
	modport sink (input valid, input plain_block, input byte_count,
		input was_decrypted, input end_of_message, output ready);
endinterface

interface hxtd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  reg_index;
	logic [31:0] wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface
`default_nettype wire

// ----- rtl/hxtd_front.sv -----
`default_nettype none
module hxtd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	hxtd_pair_if.sink             pairs,
	input  wire logic [7:0]       xor_byte,
	input  wire logic             q_full,
	output hxtd_pkg::blk_req_t    req,
	output logic                  req_vld
);
	import hxtd_pkg::*;

	logic [55:0] pend_q;
	logic [2:0]  cnt_q;
	logic        accept;
	logic [7:0]  byte_val;
	logic [63:0] blk;
	logic        full;

	assign pairs.ready = !q_full;
	assign accept = pairs.valid && pairs.ready;

	assign byte_val = hex_pair_byte(pairs.high_char, pairs.low_char) ^ xor_byte;
	assign blk = {8'h00, pend_q} | (64'(byte_val) << {cnt_q, 3'b000});
	assign full = (cnt_q == 3'd7);

	assign req_vld = accept && (full || pairs.last_pair);
	assign req.data = blk;
	assign req.count = {1'b0, cnt_q} + 4'd1;
	assign req.full = full;
	assign req.eom = pairs.last_pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (full || pairs.last_pair) begin
				pend_q <= '0;
				cnt_q <= '0;
			end else begin
				pend_q <= blk[55:0];
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/hxtd_queue.sv -----
`default_nettype none
module hxtd_queue #(
	parameter int DEPTH = hxtd_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_vld,
	input  wire hxtd_pkg::blk_req_t  wr_data,
	output logic                     full,
	output logic                     rd_vld,
	output hxtd_pkg::blk_req_t       rd_data,
	input  wire logic                rd_pop
);
	import hxtd_pkg::*;

	localparam int AW = $clog2(DEPTH);

	blk_req_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign rd_vld = (cnt_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_vld) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_vld) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (rd_pop) rd_ptr_q <= rd_ptr_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr_vld) - (AW+1)'(rd_pop);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/hxtd_back.sv -----
`default_nettype none
module hxtd_back #(
	parameter int ROUNDS = hxtd_pkg::TEA_ROUNDS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hxtd_pkg::blk_req_t  head,
	input  wire logic                head_vld,
	output logic                     pop,
	input  wire hxtd_pkg::key_t      key,
	hxtd_block_if.source             blocks
);
	import hxtd_pkg::*;

	localparam int NST = 2 * ROUNDS;

	blk_req_t          stg_q [NST];
	blk_req_t          prev_stg [NST];
	blk_req_t          nxt_stg [NST];
	logic [NST-1:0]    vld_q;
	blk_req_t          out_q;
	logic              out_vld_q;
	logic              advance;

	assign advance = !out_vld_q || blocks.ready;
	assign pop = advance && head_vld;

	for (genvar n = 0; n < NST; n++) begin : g_stage
		localparam int RND = n / 2;
		localparam logic [63:0] SUM_WIDE = 64'(TEA_DELTA) * 64'(ROUNDS - RND);
		localparam logic [31:0] SUM = SUM_WIDE[31:0];
		localparam logic ODD = ((n % 2) == 1);
		if (n == 0) begin : g_first
			assign prev_stg[n] = head;
		end else begin : g_next
			assign prev_stg[n] = stg_q[n-1];
		end
		assign nxt_stg[n] = tea_half(prev_stg[n], ODD, key, SUM);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < NST; i++) stg_q[i] <= nxt_stg[i];
			out_q <= stg_q[NST-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= {vld_q[NST-2:0], head_vld};
			out_vld_q <= vld_q[NST-1];
		end
	end

	assign blocks.valid = out_vld_q;
	assign blocks.plain_block = out_q.data;
	assign blocks.byte_count = out_q.count;
	assign blocks.was_decrypted = out_q.full;
	assign blocks.end_of_message = out_q.eom;

endmodule
`default_nettype wire

// ----- rtl/hex_xor_tea_block_decrypter.sv -----
// channel  | dir | payload
// pairs    | in  | high_char[8], low_char[8], last_pair
// blocks   | out | plain_block[64], byte_count[4], was_decrypted, end_of_message
// cfg      | in  | reg_index[3], wr_data[32]; always ready
// one hex pair per cycle while the queue is not full; a block leaves through the queue,
// the tea pipeline of 2*ROUNDS half-round stages and the output register, in that order
// arst_n clears the collector, queue pointers and pipeline valids; config resets to zero
// a stalled output freezes the pipeline; the queue absorbs blocks, then pairs stall
`default_nettype none
`include "hex_xor_tea_block_decrypter_macros.svh"
module hex_xor_tea_block_decrypter #(
	parameter int ROUNDS = hxtd_pkg::TEA_ROUNDS,
	parameter int QUEUE_DEPTH = hxtd_pkg::QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	hxtd_pair_if.sink     pairs,
	hxtd_block_if.source  blocks,
	hxtd_cfg_if.sink      cfg
);
	import hxtd_pkg::*;

	key_t        key_q;
	logic [7:0]  xor_q;
	blk_req_t    req;
	logic        req_vld;
	logic        q_full;
	blk_req_t    head;
	logic        head_vld;
	logic        pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			xor_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.reg_index)
				REG_KEY0: key_q.k0 <= cfg.wr_data;
				REG_KEY1: key_q.k1 <= cfg.wr_data;
				REG_KEY2: key_q.k2 <= cfg.wr_data;
				REG_KEY3: key_q.k3 <= cfg.wr_data;
				REG_XOR:  xor_q <= cfg.wr_data[7:0];
				default: ;
			endcase
		end
	end

	hxtd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pairs    (pairs),
		.xor_byte (xor_q),
		.q_full   (q_full),
		.req      (req),
		.req_vld  (req_vld)
	);

	hxtd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_vld  (req_vld),
		.wr_data (req),
		.full    (q_full),
		.rd_vld  (head_vld),
		.rd_data (head),
		.rd_pop  (pop)
	);

	hxtd_back #(
		.ROUNDS (ROUNDS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.head_vld (head_vld),
		.pop      (pop),
		.key      (key_q),
		.blocks   (blocks)
	);

	`HXTD_ASSERT_NEVER(a_queue_no_overflow, clk, arst_n, req_vld && q_full)
	`HXTD_ASSERT_NEVER(a_pop_needs_head, clk, arst_n, pop && !head_vld)
	`HXTD_ASSERT(a_full_is_eight, clk, arst_n, blocks.valid && blocks.was_decrypted |-> blocks.byte_count == 4'd8)
	`HXTD_ASSERT(a_mid_is_full, clk, arst_n, blocks.valid && !blocks.end_of_message |-> blocks.was_decrypted)

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import hxtd_pkg::*;

	localparam int ROUNDS = TEA_ROUNDS;
	localparam int SETTLE_CYCLES = 2 * ROUNDS + 12;
	localparam int PHASES = 5;
	localparam int PHASE_PAIRS = 260;
	localparam int HOLD_CYCLES = 400;
	localparam int LIMIT_NS = 400_000 * 12;

	typedef struct packed {
		logic [7:0] hi;
		logic [7:0] lo;
		logic       last;
	} pair_req_t;

	typedef struct packed {
		logic [2:0]  idx;
		logic [31:0] data;
	} reg_write_t;

	typedef struct packed {
		logic [63:0] plain;
		logic [3:0]  count;
		logic        decrypted;
		logic        eom;
	} block_result_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        pair_valid = 1'b0;
	logic [7:0]  pair_hi = '0;
	logic [7:0]  pair_lo = '0;
	logic        pair_last = 1'b0;
	logic        blk_ready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [2:0]  cfg_idx = '0;
	logic [31:0] cfg_data = '0;

	hxtd_pair_if  pairs_if ();
	hxtd_block_if blocks_if ();
	hxtd_cfg_if   cfg_if ();

	assign pairs_if.valid = pair_valid;
	assign pairs_if.high_char = pair_hi;
	assign pairs_if.low_char = pair_lo;
	assign pairs_if.last_pair = pair_last;
	assign blocks_if.ready = blk_ready;
	assign cfg_if.valid = cfg_valid;
	assign cfg_if.reg_index = cfg_idx;
	assign cfg_if.wr_data = cfg_data;

	hex_xor_tea_block_decrypter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pairs(pairs_if),
		.blocks(blocks_if),
		.cfg(cfg_if)
	);

	always #6 clk = ~clk;

	pair_req_t     pair_queue[$];
	reg_write_t    reg_queue[$];
	block_result_t block_expect[$];
	int            queued_pairs = 0;
	int            mismatches = 0;

	logic [31:0] key_w [4] = '{default: '0};
	logic [7:0]  xor_key = '0;
	logic [55:0] held_bytes = '0;
	int          held_count = 0;

	logic [7:0] corner_chars [16] = '{8'h30, 8'h39, 8'h61, 8'h66, 8'h41, 8'h46, 8'h00, 8'hFF,
		8'h60, 8'h61, 8'h2F, 8'h3A, 8'h66, 8'h67, 8'h7F, 8'h80};

	function automatic logic [7:0] pair_to_byte(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] h;
		logic [7:0] v;
		h = hi - ((hi > LOWER_LIM) ? ALPHA_ADJ : 8'h00) - ASCII_ZERO;
		v = {h[3:0], 4'h0} + lo;
		v = v - ((lo > LOWER_LIM) ? ALPHA_ADJ : 8'h00) - ASCII_ZERO;
		return v;
	endfunction

	function automatic logic [63:0] tea_reverse(input logic [63:0] blk);
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] sum;
		y = blk[31:0];
		z = blk[63:32];
		sum = TEA_DELTA * ROUNDS;
		for (int r = 0; r < ROUNDS; r++) begin
			z = z - (((y << 4) + key_w[2]) ^ (y + sum) ^ ((y >> 5) + key_w[3]));
			y = y - (((z << 4) + key_w[0]) ^ (z + sum) ^ ((z >> 5) + key_w[1]));
			sum = sum - TEA_DELTA;
		end
		return {z, y};
	endfunction

	task automatic absorb_pair(input logic [7:0] hi, input logic [7:0] lo, input logic last);
		logic [63:0]   blk;
		block_result_t res;
		blk = {8'h00, held_bytes};
		blk[8*held_count +: 8] = pair_to_byte(hi, lo) ^ xor_key;
		if (held_count == 7) begin
			res.plain = tea_reverse(blk);
			res.count = 4'd8;
			res.decrypted = 1'b1;
			res.eom = last;
			block_expect.push_back(res);
			held_bytes = '0;
			held_count = 0;
		end else if (last) begin
			res.plain = blk;
			res.count = 4'(held_count + 1);
			res.decrypted = 1'b0;
			res.eom = 1'b1;
			block_expect.push_back(res);
			held_bytes = '0;
			held_count = 0;
		end else begin
			held_bytes = blk[55:0];
			held_count = held_count + 1;
		end
	endtask

	// pair sender, bursts with random gaps
	int idle_left = 0;
	int burst_left = 1;

	always @(posedge clk or negedge arst_n) begin : pair_sender
		pair_req_t req;
		if (!arst_n) begin
			pair_valid <= 1'b0;
			pair_hi <= '0;
			pair_lo <= '0;
			pair_last <= 1'b0;
			idle_left = 0;
			burst_left = 1;
		end else begin
			if (pairs_if.valid && pairs_if.ready) begin
				absorb_pair(pairs_if.high_char, pairs_if.low_char, pairs_if.last_pair);
			end
			if (!pairs_if.valid || pairs_if.ready) begin
				if (idle_left != 0 || pair_queue.size() == 0) begin
					pair_valid <= 1'b0;
					if (idle_left != 0) idle_left = idle_left - 1;
				end else begin
					req = pair_queue.pop_front();
					pair_valid <= 1'b1;
					pair_hi <= req.hi;
					pair_lo <= req.lo;
					pair_last <= req.last;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left = burst_left - 1;
					end
				end
			end
		end
	end

	// register writer, predictor config follows each accepted request
	always @(posedge clk or negedge arst_n) begin : reg_writer
		reg_write_t wr;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_idx <= '0;
			cfg_data <= '0;
		end else begin
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.reg_index)
					REG_KEY0: key_w[0] = cfg_if.wr_data;
					REG_KEY1: key_w[1] = cfg_if.wr_data;
					REG_KEY2: key_w[2] = cfg_if.wr_data;
					REG_KEY3: key_w[3] = cfg_if.wr_data;
					REG_XOR: xor_key = cfg_if.wr_data[7:0];
					default: ;
				endcase
			end
			if (!cfg_if.valid || cfg_if.ready) begin
				if (reg_queue.size() != 0) begin
					wr = reg_queue.pop_front();
					cfg_valid <= 1'b1;
					cfg_idx <= wr.idx;
					cfg_data <= wr.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// block receiver with its own stall pattern and long hold-offs
	int       taken_blocks = 0;
	int       hold_left = 0;
	int       mode_left = 0;
	int       rx_tick = 0;
	rx_mode_t rx_mode = RX_OPEN;

	always @(posedge clk or negedge arst_n) begin : block_receiver
		if (!arst_n) begin
			blk_ready <= 1'b0;
		end else begin
			rx_tick = rx_tick + 1;
			if (blocks_if.valid && blocks_if.ready) taken_blocks = taken_blocks + 1;
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				blk_ready <= 1'b0;
			end else if (blocks_if.valid && blocks_if.ready &&
					(taken_blocks == 40 || taken_blocks == 150)) begin
				hold_left = HOLD_CYCLES;
				blk_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end else begin
					mode_left = mode_left - 1;
				end
				case (rx_mode)
					RX_OPEN: blk_ready <= 1'b1;
					RX_LIGHT: blk_ready <= ($urandom_range(0, 3) != 0);
					RX_HEAVY: blk_ready <= ($urandom_range(0, 3) == 0);
					default: blk_ready <= (rx_tick % 5 < 2);
				endcase
			end
		end
	end

	always @(posedge clk) begin : block_checker
		block_result_t want;
		if (arst_n && blocks_if.valid && blocks_if.ready) begin
			if (block_expect.size() == 0) begin
				$error("unexpected block %h count %0d", blocks_if.plain_block,
					blocks_if.byte_count);
				mismatches++;
			end else begin
				want = block_expect.pop_front();
				if (blocks_if.plain_block !== want.plain) begin
					$error("plain_block: expected %h, got %h", want.plain,
						blocks_if.plain_block);
					mismatches++;
				end
				if (blocks_if.byte_count !== want.count) begin
					$error("byte_count: expected %0d, got %0d", want.count,
						blocks_if.byte_count);
					mismatches++;
				end
				if (blocks_if.was_decrypted !== want.decrypted) begin
					$error("was_decrypted: expected %b, got %b", want.decrypted,
						blocks_if.was_decrypted);
					mismatches++;
				end
				if (blocks_if.end_of_message !== want.eom) begin
					$error("end_of_message: expected %b, got %b", want.eom,
						blocks_if.end_of_message);
					mismatches++;
				end
			end
		end
	end

	function automatic logic [7:0] rand_char();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'(8'h30 + $urandom_range(0, 9));
			4, 5, 6: return 8'(8'h61 + $urandom_range(0, 5));
			7: return 8'(8'h41 + $urandom_range(0, 5));
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic push_pair(input logic [7:0] hi, input logic [7:0] lo, input logic last);
		pair_queue.push_back('{hi, lo, last});
		queued_pairs++;
	endtask

	task automatic push_message();
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: n = 8 * $urandom_range(1, 4);
			6, 7: n = 8 * $urandom_range(0, 3) + $urandom_range(1, 7);
			default: n = $urandom_range(1, 40);
		endcase
		for (int i = 0; i < n; i++) push_pair(rand_char(), rand_char(), i == n - 1);
	endtask

	task automatic drain_blocks();
		while (pair_queue.size() != 0 || pair_valid) @(negedge clk);
		while (block_expect.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		reg_queue.push_back('{idx, data});
		while (reg_queue.size() != 0 || cfg_valid) @(negedge clk);
	endtask

	task automatic set_keys(input logic [31:0] k0, input logic [31:0] k1,
			input logic [31:0] k2, input logic [31:0] k3, input logic [7:0] x);
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
		write_reg(REG_XOR, {24'h000000, x});
	endtask

	initial begin : stimulus
		int target;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corner characters and block boundaries under reset config
		push_pair(8'h30, 8'h30, 1'b1);
		for (int i = 0; i < 8; i++) begin
			push_pair(corner_chars[2*i], corner_chars[2*i+1], i == 7);
		end
		for (int i = 0; i < 15; i++) push_pair(rand_char(), rand_char(), i == 14);
		drain_blocks();

		for (int ph = 0; ph < PHASES; ph++) begin
			repeat (SETTLE_CYCLES) @(negedge clk);
			for (int i = int'(REG_XOR) + 1; i < (1 << CFG_IDX_W); i++) begin
				write_reg(3'(i), $urandom());
			end
			case (ph)
				0: set_keys('1, '1, '1, '1, 8'hFF);
				1: set_keys('0, '0, '0, '0, 8'h00);
				default: set_keys($urandom(), $urandom(), $urandom(), $urandom(),
					8'($urandom()));
			endcase
			for (int half = 0; half < 2; half++) begin
				target = queued_pairs + PHASE_PAIRS / 2;
				while (queued_pairs < target) push_message();
				drain_blocks();
			end
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && block_expect.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
